### design/plstc_pkg.sv
package plstc_pkg;

    // Default sizes of the thread table and of the stored ids
    localparam int NUM_THREADS_DEF = 64;
    localparam int ID_BITS_DEF     = 16;

    // Fixed widths of the request and result fields
    localparam int KIND_W  = 2;
    localparam int TID_W   = 6;
    localparam int OID_W   = 16;
    localparam int RQ_W    = 4;
    localparam int MPH_W   = 4;
    localparam int OPH_W   = 3;
    localparam int QPH_W   = 3;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INIT   = 2'd0,
        KIND_MUTEX  = 2'd1,
        KIND_OBJECT = 2'd2,
        KIND_QUEUE  = 2'd3
    } req_kind_t;

    // Classified request control, passed from front to back
    typedef struct packed {
        req_kind_t         kind;
        logic [RQ_W-1:0]   rq;
        logic              skip;
        logic              in_range;
        logic              id_zero;
    } req_ctrl_t;

endpackage

### design/plstc_front.sv
module plstc_front #(
    parameter int NUM_THREADS = plstc_pkg::NUM_THREADS_DEF,
    parameter int ID_BITS     = plstc_pkg::ID_BITS_DEF,
    parameter int IDX_W       = $clog2(NUM_THREADS)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [plstc_pkg::KIND_W-1:0]   s_req_type,
    input  logic [plstc_pkg::TID_W-1:0]    s_thread_id,
    input  logic [plstc_pkg::OID_W-1:0]    s_object_id,
    input  logic [plstc_pkg::RQ_W-1:0]     s_requested_state,
    input  logic                           s_skip_object_check,
    input  logic                           hold_off,
    input  logic                           pop,
    output logic                           q_empty,
    output plstc_pkg::req_ctrl_t           head_ctrl,
    output logic [IDX_W-1:0]               head_idx,
    output logic [ID_BITS-1:0]             head_id
);

    typedef struct packed {
        plstc_pkg::req_ctrl_t ctrl;
        logic [IDX_W-1:0]     idx;
        logic [ID_BITS-1:0]   id;
    } q_entry_t;

    q_entry_t     q_mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    q_entry_t     in_entry;
    logic         push;

    // Classify the incoming request
    always_comb begin
        in_entry.ctrl.kind     = plstc_pkg::req_kind_t'(s_req_type);
        in_entry.ctrl.rq       = s_requested_state;
        in_entry.ctrl.skip     = s_skip_object_check;
        in_entry.ctrl.in_range = 32'(s_thread_id) < 32'(NUM_THREADS);
        in_entry.idx           = IDX_W'(s_thread_id);
        in_entry.id            = ID_BITS'(s_object_id);
        in_entry.ctrl.id_zero  = (in_entry.id == '0);
    end

    assign s_ready = (count_reg != 2'd2) && !hold_off;
    assign push    = s_valid && s_ready;
    assign q_empty = (count_reg == 2'd0);

    assign head_ctrl = q_mem_reg[rd_ptr_reg].ctrl;
    assign head_idx  = q_mem_reg[rd_ptr_reg].idx;
    assign head_id   = q_mem_reg[rd_ptr_reg].id;

    // Two-entry queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

### design/plstc_back.sv
module plstc_back #(
    parameter int NUM_THREADS = plstc_pkg::NUM_THREADS_DEF,
    parameter int ID_BITS     = plstc_pkg::ID_BITS_DEF,
    parameter int IDX_W       = $clog2(NUM_THREADS)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    output logic                           clearing,
    input  logic                           q_empty,
    output logic                           pop,
    input  plstc_pkg::req_ctrl_t           head_ctrl,
    input  logic [IDX_W-1:0]               head_idx,
    input  logic [ID_BITS-1:0]             head_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [plstc_pkg::MPH_W-1:0]    m_mutex_phase_now,
    output logic [plstc_pkg::OPH_W-1:0]    m_object_phase_now,
    output logic [plstc_pkg::QPH_W-1:0]    m_queue_phase_now
);

    // Mutex phase codes (request-only codes follow acquired exclusive)
    localparam logic [3:0] M_UNLOCKED   = 4'd0;
    localparam logic [3:0] M_BEG_SH     = 4'd1;
    localparam logic [3:0] M_BEG_EX     = 4'd2;
    localparam logic [3:0] M_BEG_DOWN   = 4'd3;
    localparam logic [3:0] M_BEG_EXUNL  = 4'd4;
    localparam logic [3:0] M_BEG_UP     = 4'd5;
    localparam logic [3:0] M_BEG_SHUNL  = 4'd6;
    localparam logic [3:0] M_ACQ_SH     = 4'd7;
    localparam logic [3:0] M_ACQ_EX     = 4'd8;
    localparam logic [3:0] M_SH_FAIL    = 4'd9;
    localparam logic [3:0] M_EX_FAIL    = 4'd10;
    localparam logic [3:0] M_DOWN_FAIL  = 4'd11;
    localparam logic [3:0] M_UP_FAIL    = 4'd12;

    // Object lock phase codes
    localparam logic [3:0] O_UNLOCKED   = 4'd0;
    localparam logic [3:0] O_BEG_TRY    = 4'd1;
    localparam logic [3:0] O_BEG_LOCK   = 4'd2;
    localparam logic [3:0] O_BEG_UNLOCK = 4'd3;
    localparam logic [3:0] O_ACQUIRED   = 4'd4;
    localparam logic [3:0] O_LOCK_FAIL  = 4'd5;

    // Queue phase codes
    localparam logic [3:0] Q_UNUSED     = 4'd0;
    localparam logic [3:0] Q_LAST_OP    = 4'd7;

    typedef struct packed {
        logic [plstc_pkg::MPH_W-1:0] mph;
        logic [ID_BITS-1:0]          mhold;
        logic [plstc_pkg::OPH_W-1:0] oph;
        logic [ID_BITS-1:0]          ohold;
        logic [plstc_pkg::QPH_W-1:0] qph;
        logic [ID_BITS-1:0]          qhold;
    } entry_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_FETCH,
        S_EXEC
    } state_t;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            clr_cnt_reg, clr_cnt_next;
    plstc_pkg::req_ctrl_t        cur_ctrl_reg, cur_ctrl_next;
    logic [IDX_W-1:0]            cur_idx_reg, cur_idx_next;
    logic [ID_BITS-1:0]          cur_id_reg, cur_id_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        acc_reg, acc_next;
    logic [plstc_pkg::MPH_W-1:0] mph_out_reg, mph_out_next;
    logic [plstc_pkg::OPH_W-1:0] oph_out_reg, oph_out_next;
    logic [plstc_pkg::QPH_W-1:0] qph_out_reg, qph_out_next;

    entry_t                      mem [NUM_THREADS];
    entry_t                      rd_data_reg;
    logic                        rd_en;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    entry_t                      wr_data;

    entry_t                      old_e, new_e;
    logic                        ok;
    logic                        obj_free, q_free, m_mine, o_mine;
    logic                        out_free;

    assign clearing = (state_reg == S_CLEAR);
    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == S_FETCH) && !q_empty;
    assign rd_en    = pop && head_ctrl.in_range;

    // Transition check against the stored entry
    always_comb begin
        old_e    = rd_data_reg;
        new_e    = old_e;
        ok       = 1'b0;
        obj_free = (old_e.oph == '0) && (old_e.ohold == '0);
        q_free   = (old_e.qph == '0) && (old_e.qhold == '0);
        m_mine   = (old_e.mhold == cur_id_reg);
        o_mine   = (old_e.ohold == cur_id_reg);
        if (!cur_ctrl_reg.in_range) begin
            ok = 1'b0;
        end else if (cur_ctrl_reg.kind == plstc_pkg::KIND_INIT) begin
            new_e = '0;
            ok    = 1'b1;
        end else if (!cur_ctrl_reg.id_zero) begin
            case (cur_ctrl_reg.kind)
                plstc_pkg::KIND_MUTEX: begin
                    if ((cur_ctrl_reg.skip || obj_free) && q_free) begin
                        case (cur_ctrl_reg.rq)
                            M_UNLOCKED: begin
                                ok = m_mine && (old_e.mph == M_BEG_SHUNL
                                                || old_e.mph == M_BEG_EXUNL);
                                if (ok) begin
                                    new_e.mhold = '0;
                                    new_e.mph   = M_UNLOCKED;
                                end
                            end
                            M_BEG_SH, M_BEG_EX: begin
                                ok = (old_e.mhold == '0) && (old_e.mph == M_UNLOCKED);
                                if (ok) begin
                                    new_e.mhold = cur_id_reg;
                                    new_e.mph   = cur_ctrl_reg.rq;
                                end
                            end
                            M_BEG_DOWN, M_BEG_EXUNL: begin
                                ok = m_mine && (old_e.mph == M_ACQ_EX);
                                if (ok) new_e.mph = cur_ctrl_reg.rq;
                            end
                            M_BEG_UP, M_BEG_SHUNL: begin
                                ok = m_mine && (old_e.mph == M_ACQ_SH);
                                if (ok) new_e.mph = cur_ctrl_reg.rq;
                            end
                            M_ACQ_SH: begin
                                ok = m_mine && (old_e.mph == M_BEG_SH
                                                || old_e.mph == M_BEG_DOWN);
                                if (ok) new_e.mph = M_ACQ_SH;
                            end
                            M_ACQ_EX: begin
                                ok = m_mine && (old_e.mph == M_BEG_EX
                                                || old_e.mph == M_BEG_UP);
                                if (ok) new_e.mph = M_ACQ_EX;
                            end
                            M_SH_FAIL, M_EX_FAIL: begin
                                ok = m_mine && (old_e.mph == ((cur_ctrl_reg.rq == M_SH_FAIL)
                                                ? M_BEG_SH : M_BEG_EX));
                                if (ok) begin
                                    new_e.mhold = '0;
                                    new_e.mph   = M_UNLOCKED;
                                end
                            end
                            M_DOWN_FAIL: begin
                                ok = m_mine && (old_e.mph == M_BEG_DOWN);
                                if (ok) new_e.mph = M_ACQ_SH;
                            end
                            M_UP_FAIL: begin
                                ok = m_mine && (old_e.mph == M_BEG_UP);
                                if (ok) new_e.mph = M_ACQ_EX;
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                end
                plstc_pkg::KIND_OBJECT: begin
                    if (q_free) begin
                        case (cur_ctrl_reg.rq)
                            O_UNLOCKED: begin
                                ok = o_mine && (4'(old_e.oph) == O_BEG_UNLOCK);
                                if (ok) begin
                                    new_e.ohold = '0;
                                    new_e.oph   = '0;
                                end
                            end
                            O_BEG_TRY, O_BEG_LOCK: begin
                                ok = (old_e.ohold == '0) && (4'(old_e.oph) == O_UNLOCKED);
                                if (ok) begin
                                    new_e.ohold = cur_id_reg;
                                    new_e.oph   = cur_ctrl_reg.rq[plstc_pkg::OPH_W-1:0];
                                end
                            end
                            O_BEG_UNLOCK: begin
                                ok = o_mine && (4'(old_e.oph) == O_ACQUIRED);
                                if (ok) new_e.oph = O_BEG_UNLOCK[plstc_pkg::OPH_W-1:0];
                            end
                            O_ACQUIRED: begin
                                ok = o_mine && (4'(old_e.oph) == O_BEG_TRY
                                                || 4'(old_e.oph) == O_BEG_LOCK);
                                if (ok) new_e.oph = O_ACQUIRED[plstc_pkg::OPH_W-1:0];
                            end
                            O_LOCK_FAIL: begin
                                ok = o_mine && (4'(old_e.oph) == O_BEG_TRY);
                                if (ok) begin
                                    new_e.ohold = '0;
                                    new_e.oph   = '0;
                                end
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                end
                plstc_pkg::KIND_QUEUE: begin
                    if (cur_ctrl_reg.rq == Q_UNUSED) begin
                        ok = (old_e.qhold == cur_id_reg) && (old_e.qph != '0);
                        if (ok) begin
                            new_e.qhold = '0;
                            new_e.qph   = '0;
                        end
                    end else if (cur_ctrl_reg.rq <= Q_LAST_OP) begin
                        ok = q_free;
                        if (ok) begin
                            new_e.qhold = cur_id_reg;
                            new_e.qph   = cur_ctrl_reg.rq[plstc_pkg::QPH_W-1:0];
                        end
                    end
                end
                default: ok = 1'b0;
            endcase
        end
    end

    // Table write port: clearing sweep or an applied transition
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_idx_reg;
        wr_data = new_e;
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end else if (state_reg == S_EXEC && out_free && ok) begin
            wr_en = 1'b1;
        end
    end

    // Sequencer and result register
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_ctrl_next = cur_ctrl_reg;
        cur_idx_next  = cur_idx_reg;
        cur_id_next   = cur_id_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        acc_next      = acc_reg;
        mph_out_next  = mph_out_reg;
        oph_out_next  = oph_out_reg;
        qph_out_next  = qph_out_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(NUM_THREADS - 1)) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                if (pop) begin
                    cur_ctrl_next = head_ctrl;
                    cur_idx_next  = head_idx;
                    cur_id_next   = head_id;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    acc_next     = ok;
                    if (cur_ctrl_reg.in_range) begin
                        mph_out_next = new_e.mph;
                        oph_out_next = new_e.oph;
                        qph_out_next = new_e.qph;
                    end else begin
                        mph_out_next = '0;
                        oph_out_next = '0;
                        qph_out_next = '0;
                    end
                    state_next = S_FETCH;
                end
            end
            default: state_next = S_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        cur_ctrl_reg <= cur_ctrl_next;
        cur_idx_reg  <= cur_idx_next;
        cur_id_reg   <= cur_id_next;
        acc_reg      <= acc_next;
        mph_out_reg  <= mph_out_next;
        oph_out_reg  <= oph_out_next;
        qph_out_reg  <= qph_out_next;
    end

    // Per-thread table, one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[head_idx];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_accepted         = acc_reg;
    assign m_mutex_phase_now  = mph_out_reg;
    assign m_object_phase_now = oph_out_reg;
    assign m_queue_phase_now  = qph_out_reg;

endmodule

### design/per_thread_lock_state_checker_unit.sv
// Path: two-entry front queue, registered table read, result register; the back end
// holds a request while the output is not free, and takes the next one only after the
// table read and the update write of the current request's entry.
// Reset: synchronous, active low; afterwards the table is cleared by a sweep over all
// NUM_THREADS entries, one entry a cycle, during which s_ready stays low.
module per_thread_lock_state_checker_unit #(
    parameter int NUM_THREADS = plstc_pkg::NUM_THREADS_DEF,
    parameter int ID_BITS     = plstc_pkg::ID_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [plstc_pkg::KIND_W-1:0]   s_req_type,
    input  logic [plstc_pkg::TID_W-1:0]    s_thread_id,
    input  logic [plstc_pkg::OID_W-1:0]    s_object_id,
    input  logic [plstc_pkg::RQ_W-1:0]     s_requested_state,
    input  logic                           s_skip_object_check,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [plstc_pkg::MPH_W-1:0]    m_mutex_phase_now,
    output logic [plstc_pkg::OPH_W-1:0]    m_object_phase_now,
    output logic [plstc_pkg::QPH_W-1:0]    m_queue_phase_now
);

    localparam int IDX_W = $clog2(NUM_THREADS);

    logic                    clearing;
    logic                    pop;
    logic                    q_empty;
    plstc_pkg::req_ctrl_t    head_ctrl;
    logic [IDX_W-1:0]        head_idx;
    logic [ID_BITS-1:0]      head_id;

    // Front end: accept, classify and queue requests
    plstc_front #(
        .NUM_THREADS (NUM_THREADS),
        .ID_BITS     (ID_BITS),
        .IDX_W       (IDX_W)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_thread_id         (s_thread_id),
        .s_object_id         (s_object_id),
        .s_requested_state   (s_requested_state),
        .s_skip_object_check (s_skip_object_check),
        .hold_off            (clearing),
        .pop                 (pop),
        .q_empty             (q_empty),
        .head_ctrl           (head_ctrl),
        .head_idx            (head_idx),
        .head_id             (head_id)
    );

    // Back end: table read-modify-write and result register
    plstc_back #(
        .NUM_THREADS (NUM_THREADS),
        .ID_BITS     (ID_BITS),
        .IDX_W       (IDX_W)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .clearing           (clearing),
        .q_empty            (q_empty),
        .pop                (pop),
        .head_ctrl          (head_ctrl),
        .head_idx           (head_idx),
        .head_id            (head_id),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accepted         (m_accepted),
        .m_mutex_phase_now  (m_mutex_phase_now),
        .m_object_phase_now (m_object_phase_now),
        .m_queue_phase_now  (m_queue_phase_now)
    );

endmodule

### bench/lock_state_monitor.sv
`timescale 1ns / 1ps

package lock_codes_pkg;

    // Mutex phase codes; the four "failed" codes exist only as requests
    localparam logic [3:0] MX_UNLOCKED            = 4'd0;
    localparam logic [3:0] MX_BEGIN_SHARED        = 4'd1;
    localparam logic [3:0] MX_BEGIN_EXCL          = 4'd2;
    localparam logic [3:0] MX_BEGIN_DOWNGRADE     = 4'd3;
    localparam logic [3:0] MX_BEGIN_EXCL_UNLOCK   = 4'd4;
    localparam logic [3:0] MX_BEGIN_UPGRADE       = 4'd5;
    localparam logic [3:0] MX_BEGIN_SHARED_UNLOCK = 4'd6;
    localparam logic [3:0] MX_SHARED             = 4'd7;
    localparam logic [3:0] MX_EXCL               = 4'd8;
    localparam logic [3:0] MX_SHARED_FAILED      = 4'd9;
    localparam logic [3:0] MX_EXCL_FAILED        = 4'd10;
    localparam logic [3:0] MX_DOWNGRADE_FAILED   = 4'd11;
    localparam logic [3:0] MX_UPGRADE_FAILED     = 4'd12;

    // Object lock phase codes; lock failed is request-only
    localparam logic [2:0] OB_UNLOCKED     = 3'd0;
    localparam logic [2:0] OB_BEGIN_TRY    = 3'd1;
    localparam logic [2:0] OB_BEGIN_LOCK   = 3'd2;
    localparam logic [2:0] OB_BEGIN_UNLOCK = 3'd3;
    localparam logic [2:0] OB_ACQUIRED     = 3'd4;
    localparam logic [2:0] OB_LOCK_FAILED  = 3'd5;

    // Queue operation codes
    localparam logic [2:0] Q_UNUSED      = 3'd0;
    localparam logic [2:0] Q_TRY_GET     = 3'd1;
    localparam logic [2:0] Q_GET         = 3'd2;
    localparam logic [2:0] Q_PUT         = 3'd3;
    localparam logic [2:0] Q_GET_CAP     = 3'd4;
    localparam logic [2:0] Q_GET_MAX_CAP = 3'd5;
    localparam logic [2:0] Q_SET_CAP     = 3'd6;
    localparam logic [2:0] Q_SET_MAX_CAP = 3'd7;

endpackage

module lock_state_monitor #(
    parameter int NUM_THREADS = plstc_pkg::NUM_THREADS_DEF,
    parameter int ID_BITS     = plstc_pkg::ID_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [plstc_pkg::KIND_W-1:0]   s_req_type,
    input  logic [plstc_pkg::TID_W-1:0]    s_thread_id,
    input  logic [plstc_pkg::OID_W-1:0]    s_object_id,
    input  logic [plstc_pkg::RQ_W-1:0]     s_requested_state,
    input  logic                           s_skip_object_check,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_accepted,
    input  logic [plstc_pkg::MPH_W-1:0]    m_mutex_phase_now,
    input  logic [plstc_pkg::OPH_W-1:0]    m_object_phase_now,
    input  logic [plstc_pkg::QPH_W-1:0]    m_queue_phase_now,
    output int                             failures,
    output int                             outstanding
);

    import plstc_pkg::*;
    import lock_codes_pkg::*;

    typedef struct packed {
        logic             accepted;
        logic [MPH_W-1:0] mutex_ph;
        logic [OPH_W-1:0] object_ph;
        logic [QPH_W-1:0] queue_ph;
    } lock_view_t;

    // Shadow of the per-thread lock table
    logic [MPH_W-1:0]   mx_ph  [NUM_THREADS];
    logic [ID_BITS-1:0] mx_own [NUM_THREADS];
    logic [OPH_W-1:0]   ob_ph  [NUM_THREADS];
    logic [ID_BITS-1:0] ob_own [NUM_THREADS];
    logic [QPH_W-1:0]   q_ph   [NUM_THREADS];
    logic [ID_BITS-1:0] q_own  [NUM_THREADS];

    lock_view_t expected_views[$];
    lock_view_t seen_view;
    lock_view_t want_view;
    int         fail_tally = 0;

    // Apply one request to the shadow table and return the view it leaves
    function automatic lock_view_t predict_lock_step(req_kind_t kind, logic [TID_W-1:0] tid,
                                                     logic [OID_W-1:0] oid,
                                                     logic [RQ_W-1:0] rq, logic skip);
        lock_view_t         v;
        int                 t;
        logic [ID_BITS-1:0] id;
        logic               ok;
        logic               mine;
        logic               obj_free;
        logic               q_free;

        v = '0;
        if (int'(tid) >= NUM_THREADS)
            return v;
        t        = int'(tid);
        id       = ID_BITS'(oid);
        ok       = 1'b0;
        obj_free = (ob_ph[t] == OB_UNLOCKED) && (ob_own[t] == '0);
        q_free   = (q_ph[t] == Q_UNUSED) && (q_own[t] == '0);

        case (kind)
            KIND_INIT: begin
                mx_ph[t] = MX_UNLOCKED;  mx_own[t] = '0;
                ob_ph[t] = OB_UNLOCKED;  ob_own[t] = '0;
                q_ph[t]  = Q_UNUSED;     q_own[t]  = '0;
                ok = 1'b1;
            end
            KIND_MUTEX: begin
                mine = (mx_own[t] == id);
                if (id != '0 && (skip || obj_free) && q_free) begin
                    case (rq)
                        MX_UNLOCKED: if (mine && (mx_ph[t] == MX_BEGIN_SHARED_UNLOCK ||
                                                  mx_ph[t] == MX_BEGIN_EXCL_UNLOCK)) begin
                            mx_own[t] = '0; mx_ph[t] = MX_UNLOCKED; ok = 1'b1;
                        end
                        MX_BEGIN_SHARED, MX_BEGIN_EXCL:
                            if (mx_own[t] == '0 && mx_ph[t] == MX_UNLOCKED) begin
                                mx_own[t] = id; mx_ph[t] = rq; ok = 1'b1;
                            end
                        MX_BEGIN_DOWNGRADE, MX_BEGIN_EXCL_UNLOCK:
                            if (mine && mx_ph[t] == MX_EXCL) begin
                                mx_ph[t] = rq; ok = 1'b1;
                            end
                        MX_BEGIN_UPGRADE, MX_BEGIN_SHARED_UNLOCK:
                            if (mine && mx_ph[t] == MX_SHARED) begin
                                mx_ph[t] = rq; ok = 1'b1;
                            end
                        MX_SHARED: if (mine && (mx_ph[t] == MX_BEGIN_SHARED ||
                                                mx_ph[t] == MX_BEGIN_DOWNGRADE)) begin
                            mx_ph[t] = MX_SHARED; ok = 1'b1;
                        end
                        MX_EXCL: if (mine && (mx_ph[t] == MX_BEGIN_EXCL ||
                                              mx_ph[t] == MX_BEGIN_UPGRADE)) begin
                            mx_ph[t] = MX_EXCL; ok = 1'b1;
                        end
                        // failed lock attempts drop the mutex altogether
                        MX_SHARED_FAILED: if (mine && mx_ph[t] == MX_BEGIN_SHARED) begin
                            mx_own[t] = '0; mx_ph[t] = MX_UNLOCKED; ok = 1'b1;
                        end
                        MX_EXCL_FAILED: if (mine && mx_ph[t] == MX_BEGIN_EXCL) begin
                            mx_own[t] = '0; mx_ph[t] = MX_UNLOCKED; ok = 1'b1;
                        end
                        // a failed downgrade ends in shared, a failed upgrade in exclusive
                        MX_DOWNGRADE_FAILED: if (mine && mx_ph[t] == MX_BEGIN_DOWNGRADE) begin
                            mx_ph[t] = MX_SHARED; ok = 1'b1;
                        end
                        MX_UPGRADE_FAILED: if (mine && mx_ph[t] == MX_BEGIN_UPGRADE) begin
                            mx_ph[t] = MX_EXCL; ok = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            KIND_OBJECT: begin
                mine = (ob_own[t] == id);
                if (id != '0 && q_free) begin
                    case (rq)
                        OB_UNLOCKED: if (mine && ob_ph[t] == OB_BEGIN_UNLOCK) begin
                            ob_own[t] = '0; ob_ph[t] = OB_UNLOCKED; ok = 1'b1;
                        end
                        OB_BEGIN_TRY, OB_BEGIN_LOCK:
                            if (ob_own[t] == '0 && ob_ph[t] == OB_UNLOCKED) begin
                                ob_own[t] = id; ob_ph[t] = OPH_W'(rq); ok = 1'b1;
                            end
                        OB_BEGIN_UNLOCK: if (mine && ob_ph[t] == OB_ACQUIRED) begin
                            ob_ph[t] = OB_BEGIN_UNLOCK; ok = 1'b1;
                        end
                        OB_ACQUIRED: if (mine && (ob_ph[t] == OB_BEGIN_TRY ||
                                                  ob_ph[t] == OB_BEGIN_LOCK)) begin
                            ob_ph[t] = OB_ACQUIRED; ok = 1'b1;
                        end
                        OB_LOCK_FAILED: if (mine && ob_ph[t] == OB_BEGIN_TRY) begin
                            ob_own[t] = '0; ob_ph[t] = OB_UNLOCKED; ok = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                // queue: any operation starts from unused, only the holder ends it
                if (id != '0) begin
                    if (rq == Q_UNUSED) begin
                        if (q_own[t] == id && q_ph[t] != Q_UNUSED) begin
                            q_own[t] = '0; q_ph[t] = Q_UNUSED; ok = 1'b1;
                        end
                    end else if (rq <= Q_SET_MAX_CAP) begin
                        if (q_own[t] == '0 && q_ph[t] == Q_UNUSED) begin
                            q_own[t] = id; q_ph[t] = QPH_W'(rq); ok = 1'b1;
                        end
                    end
                end
            end
        endcase

        v.accepted  = ok;
        v.mutex_ph  = mx_ph[t];
        v.object_ph = ob_ph[t];
        v.queue_ph  = q_ph[t];
        return v;
    endfunction

    // Results are retired before the request of the same edge is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                mx_ph[i] = MX_UNLOCKED;  mx_own[i] = '0;
                ob_ph[i] = OB_UNLOCKED;  ob_own[i] = '0;
                q_ph[i]  = Q_UNUSED;     q_own[i]  = '0;
            end
            expected_views.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen_view = '{m_accepted, m_mutex_phase_now, m_object_phase_now,
                              m_queue_phase_now};
                if (expected_views.size() == 0) begin
                    if (fail_tally < 10)
                        $display("%0t: result with nothing outstanding: acc=%0b mx=%0d ob=%0d q=%0d",
                                 $time, seen_view.accepted, seen_view.mutex_ph,
                                 seen_view.object_ph, seen_view.queue_ph);
                    fail_tally++;
                end else begin
                    want_view = expected_views.pop_front();
                    if (seen_view !== want_view) begin
                        if (fail_tally < 10)
                            $display("%0t: mismatch: expected acc=%0b mx=%0d ob=%0d q=%0d, got acc=%0b mx=%0d ob=%0d q=%0d",
                                     $time, want_view.accepted, want_view.mutex_ph,
                                     want_view.object_ph, want_view.queue_ph,
                                     seen_view.accepted, seen_view.mutex_ph,
                                     seen_view.object_ph, seen_view.queue_ph);
                        fail_tally++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_views.push_back(predict_lock_step(req_kind_t'(s_req_type), s_thread_id,
                                                           s_object_id, s_requested_state,
                                                           s_skip_object_check));
        end
        failures    <= fail_tally;
        outstanding <= expected_views.size();
    end

endmodule

### bench/tb_per_thread_lock_state_checker_unit.sv
`timescale 1ns / 1ps

module tb_per_thread_lock_state_checker_unit;

    import plstc_pkg::*;
    import lock_codes_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int IDLE_PERCENT  = 11;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [KIND_W-1:0] s_req_type;
    logic [TID_W-1:0]  s_thread_id;
    logic [OID_W-1:0]  s_object_id;
    logic [RQ_W-1:0]   s_requested_state;
    logic              s_skip_object_check;
    logic              m_valid;
    logic              m_ready;
    logic              m_accepted;
    logic [MPH_W-1:0]  m_mutex_phase_now;
    logic [OPH_W-1:0]  m_object_phase_now;
    logic [QPH_W-1:0]  m_queue_phase_now;

    int failures;
    int outstanding;
    int stall_cycles = 0;
    int sent = 0;
    bit steady = 1'b0;

    per_thread_lock_state_checker_unit uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_thread_id         (s_thread_id),
        .s_object_id         (s_object_id),
        .s_requested_state   (s_requested_state),
        .s_skip_object_check (s_skip_object_check),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accepted          (m_accepted),
        .m_mutex_phase_now   (m_mutex_phase_now),
        .m_object_phase_now  (m_object_phase_now),
        .m_queue_phase_now   (m_queue_phase_now)
    );

    lock_state_monitor lock_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_thread_id         (s_thread_id),
        .s_object_id         (s_object_id),
        .s_requested_state   (s_requested_state),
        .s_skip_object_check (s_skip_object_check),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accepted          (m_accepted),
        .m_mutex_phase_now   (m_mutex_phase_now),
        .m_object_phase_now  (m_object_phase_now),
        .m_queue_phase_now   (m_queue_phase_now),
        .failures            (failures),
        .outstanding         (outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn || steady)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic issue(req_kind_t kind, logic [TID_W-1:0] tid, logic [OID_W-1:0] oid,
                         logic [RQ_W-1:0] rq, logic skip);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_req_type          <= kind;
        s_thread_id         <= tid;
        s_object_id         <= oid;
        s_requested_state   <= rq;
        s_skip_object_check <= skip;
        do @(posedge aclk); while (!s_ready);
        sent++;
        steady = (sent >= 800 && sent < 1100);
        @(negedge aclk);
    endtask

    function automatic logic [OID_W-1:0] random_id();
        case ($urandom_range(0, 15))
            0:       return 16'h0001;
            1:       return 16'hFFFF;
            default: return OID_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // A legal next request from the phase the sequence believes it is in
    function automatic logic [RQ_W-1:0] pick_next(req_kind_t kind, logic [RQ_W-1:0] ph);
        bit coin = 1'($urandom_range(0, 1));
        if (kind == KIND_MUTEX) begin
            case (ph)
                MX_UNLOCKED:        return coin ? MX_BEGIN_SHARED : MX_BEGIN_EXCL;
                MX_BEGIN_SHARED:    return coin ? MX_SHARED : MX_SHARED_FAILED;
                MX_BEGIN_EXCL:      return coin ? MX_EXCL : MX_EXCL_FAILED;
                MX_BEGIN_DOWNGRADE: return coin ? MX_SHARED : MX_DOWNGRADE_FAILED;
                MX_BEGIN_UPGRADE:   return coin ? MX_EXCL : MX_UPGRADE_FAILED;
                MX_SHARED:          return coin ? MX_BEGIN_UPGRADE : MX_BEGIN_SHARED_UNLOCK;
                MX_EXCL:            return coin ? MX_BEGIN_DOWNGRADE : MX_BEGIN_EXCL_UNLOCK;
                default:            return MX_UNLOCKED;
            endcase
        end else if (kind == KIND_OBJECT) begin
            case (ph)
                OB_UNLOCKED:   return RQ_W'(coin ? OB_BEGIN_TRY : OB_BEGIN_LOCK);
                OB_BEGIN_TRY:  return RQ_W'(coin ? OB_ACQUIRED : OB_LOCK_FAILED);
                OB_BEGIN_LOCK: return RQ_W'(OB_ACQUIRED);
                OB_ACQUIRED:   return RQ_W'(OB_BEGIN_UNLOCK);
                default:       return RQ_W'(OB_UNLOCKED);
            endcase
        end
        return (ph == Q_UNUSED) ? RQ_W'($urandom_range(Q_TRY_GET, Q_SET_MAX_CAP))
                                : RQ_W'(Q_UNUSED);
    endfunction

    // Phase that a granted request leaves behind, failed codes folded back
    function automatic logic [RQ_W-1:0] phase_after(req_kind_t kind, logic [RQ_W-1:0] rq);
        if (kind == KIND_MUTEX) begin
            case (rq)
                MX_SHARED_FAILED, MX_EXCL_FAILED: return MX_UNLOCKED;
                MX_DOWNGRADE_FAILED:              return MX_SHARED;
                MX_UPGRADE_FAILED:                return MX_EXCL;
                default:                          return rq;
            endcase
        end
        if (kind == KIND_OBJECT && rq == OB_LOCK_FAILED)
            return RQ_W'(OB_UNLOCKED);
        return rq;
    endfunction

    initial begin
        logic [TID_W-1:0] tid;
        logic [OID_W-1:0] mx_id, ob_id, q_id;
        logic [RQ_W-1:0]  mx_at, ob_at, q_at, code;
        req_kind_t        kind;
        logic             skip;
        int               r;

        aresetn             = 1'b0;
        s_valid             = 1'b0;
        s_req_type          = '0;
        s_thread_id         = '0;
        s_object_id         = '0;
        s_requested_state   = '0;
        s_skip_object_check = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Full exclusive cycle on thread 0 with both up/downgrade failures
        issue(KIND_INIT,  6'd0, 16'hFFFF, 4'd15, 1'b1);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_BEGIN_EXCL, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_SHARED, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'hFFFF, MX_EXCL, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_EXCL, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_BEGIN_DOWNGRADE, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_DOWNGRADE_FAILED, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_BEGIN_UPGRADE, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_UPGRADE_FAILED, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_BEGIN_EXCL_UNLOCK, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0001, MX_UNLOCKED, 1'b0);
        // unknown mutex code, then a zero id
        issue(KIND_MUTEX, 6'd0, 16'h0001, 4'd13, 1'b0);
        issue(KIND_MUTEX, 6'd0, 16'h0000, MX_BEGIN_SHARED, 1'b0);
        // held object blocks the mutex unless the skip flag is set
        issue(KIND_OBJECT, 6'd63, 16'hFFFF, RQ_W'(OB_BEGIN_TRY), 1'b0);
        issue(KIND_MUTEX,  6'd63, 16'h0005, MX_BEGIN_SHARED, 1'b0);
        issue(KIND_MUTEX,  6'd63, 16'h0005, MX_BEGIN_SHARED, 1'b1);
        issue(KIND_OBJECT, 6'd63, 16'hFFFF, RQ_W'(OB_LOCK_FAILED), 1'b0);
        // a queue in use blocks both mutex and object steps
        issue(KIND_QUEUE,  6'd63, 16'h8000, RQ_W'(Q_SET_MAX_CAP), 1'b0);
        issue(KIND_OBJECT, 6'd63, 16'h7FFF, RQ_W'(OB_BEGIN_LOCK), 1'b0);
        issue(KIND_MUTEX,  6'd63, 16'h0005, MX_SHARED, 1'b1);
        issue(KIND_QUEUE,  6'd63, 16'h7FFF, RQ_W'(Q_UNUSED), 1'b0);
        issue(KIND_QUEUE,  6'd63, 16'h8000, RQ_W'(Q_UNUSED), 1'b0);
        issue(KIND_OBJECT, 6'd63, 16'h7FFF, 4'd7, 1'b0);
        issue(KIND_QUEUE,  6'd63, 16'h7FFF, 4'd15, 1'b0);
        issue(KIND_INIT,   6'd63, 16'h0000, 4'd0, 1'b0);

        // Random walks through legal sequences, one thread at a time, with noise
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tid   = ($urandom_range(0, 3) == 0) ? TID_W'($urandom_range(0, 63))
                                                : TID_W'($urandom_range(0, 7));
            mx_id = random_id();
            ob_id = random_id();
            q_id  = random_id();
            mx_at = MX_UNLOCKED;
            ob_at = RQ_W'(OB_UNLOCKED);
            q_at  = RQ_W'(Q_UNUSED);
            issue(KIND_INIT, tid, OID_W'($urandom), RQ_W'($urandom), 1'($urandom));
            repeat ($urandom_range(4, 24)) begin
                if ($urandom_range(0, 9) == 0) begin
                    issue(req_kind_t'($urandom_range(0, 3)),
                          $urandom_range(0, 1) ? tid : TID_W'($urandom_range(0, 63)),
                          ($urandom_range(0, 7) == 0) ? '0 : OID_W'($urandom),
                          RQ_W'($urandom_range(0, 15)), 1'($urandom));
                end else begin
                    r    = $urandom_range(0, 9);
                    kind = (r < 5) ? KIND_MUTEX : (r < 8) ? KIND_OBJECT : KIND_QUEUE;
                    // usually release a busy queue before touching the locks
                    if (q_at != Q_UNUSED && kind != KIND_QUEUE && $urandom_range(0, 3) != 0)
                        kind = KIND_QUEUE;
                    case (kind)
                        KIND_MUTEX: begin
                            code = pick_next(kind, mx_at);
                            skip = (ob_at != OB_UNLOCKED) ? ($urandom_range(0, 7) != 0)
                                                          : 1'($urandom);
                            issue(kind, tid, mx_id, code, skip);
                            mx_at = phase_after(kind, code);
                        end
                        KIND_OBJECT: begin
                            code = pick_next(kind, ob_at);
                            issue(kind, tid, ob_id, code, 1'($urandom));
                            ob_at = phase_after(kind, code);
                        end
                        default: begin
                            code = pick_next(kind, q_at);
                            issue(kind, tid, q_id, code, 1'($urandom));
                            q_at = phase_after(kind, code);
                        end
                    endcase
                end
            end
        end
        s_valid <= 1'b0;

        // Drain, then allow for the pipeline latency
        while (outstanding != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (failures == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
design/plstc_pkg.sv
design/plstc_front.sv
design/plstc_back.sv
design/per_thread_lock_state_checker_unit.sv
bench/lock_state_monitor.sv
bench/tb_per_thread_lock_state_checker_unit.sv
